FILE: hdl/kle_pkg.sv
// ----------------------------------------------------------------------------
// kle_pkg: shared constants and types of the keystroke line editor
// Line depth, counter and address widths, key codes, store port requests.
// ----------------------------------------------------------------------------
package kle_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    localparam logic [7:0] KEY_BACK  = 8'h2D;
    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

FILE: hdl/kle_chan_if.sv
// ----------------------------------------------------------------------------
// kle_chan_if: valid/ready channels of the keystroke line editor
// Keystroke channel in, line character channel out.
// ----------------------------------------------------------------------------
interface kle_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key;
    logic       end_of_line;

    modport source (output valid, key, end_of_line, input ready);
    modport sink   (input valid, key, end_of_line, output ready);
endinterface

interface kle_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       has_char;
    logic       last;
    logic       overflowed;

    modport source (output valid, text_char, has_char, last, overflowed, input ready);
    modport sink   (input valid, text_char, has_char, last, overflowed, output ready);
endinterface

FILE: hdl/kle_gap_store.sv
// ----------------------------------------------------------------------------
// kle_gap_store: gap buffer storage
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module kle_gap_store
    import kle_pkg::*;
(
    input  logic       i_clk,
    input  t_wr_req    i_wr,
    input  t_rd_req    i_rd,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [LINE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/keystroke_line_editor.sv
// ----------------------------------------------------------------------------
// keystroke_line_editor: gap buffer line editor
//
//   channel   dir   payload                                    transfer when
//   i_key     in    key, end_of_line                           valid & ready
//   o_line    out   text_char, has_char, last, overflowed      valid & ready
//
// Insert, backspace and a blocked cursor move complete in idle; a cursor
// move reads the store, then writes back. A flush reads one character per
// cycle unless the output stalls, set by the single store read port.
// Reset clears counts, overflow flag and output valid; store is not cleared.
// Keystrokes are taken only in idle; output stalls hold the flush read.
// ----------------------------------------------------------------------------
module keystroke_line_editor
    import kle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    kle_key_if.sink       i_key,
    kle_line_if.source    o_line
);

    typedef enum logic [1:0] {S_IDLE, S_MOVE, S_FLUSH, S_EMPTY} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_right;
    logic             r_ovf;
    logic             r_move_left;
    logic [CNT_W-1:0] r_pos;
    logic             r_rd_pend;
    logic             r_rd_last;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_has;
    logic             r_out_last;
    logic             r_out_ovf;

    logic             w_key_acc;
    logic             w_out_free;
    logic [CNT_W-1:0] w_total;
    logic [CNT_W-1:0] w_base;
    logic             w_full;
    logic             w_more;
    logic             w_issue;
    logic             w_load;
    logic [CNT_W-1:0] w_flush_addr;
    logic [7:0]       w_rd_data;
    t_wr_req          w_wr;
    t_rd_req          w_rd;

    assign w_key_acc  = i_key.valid && i_key.ready;
    assign w_out_free = !r_out_valid || o_line.ready;
    assign w_total    = r_left + r_right;
    assign w_base     = CNT_W'(LINE_DEPTH) - r_right;
    assign w_full     = (w_total == CNT_W'(LINE_DEPTH));
    assign w_more     = (r_state == S_FLUSH) && (r_pos != w_total);
    assign w_issue    = w_more && (!r_rd_pend || w_out_free);
    assign w_load     = (r_state == S_FLUSH) && r_rd_pend && w_out_free;
    assign w_flush_addr = (r_pos < r_left) ? r_pos : (r_pos - r_left + w_base);

    always_comb begin
        w_wr.en   = 1'b0;
        w_wr.addr = r_left[ADDR_W-1:0];
        w_wr.data = i_key.key;
        w_rd.en   = 1'b0;
        w_rd.addr = w_flush_addr[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_key_acc && !i_key.end_of_line) begin
                    case (i_key.key)
                        KEY_BACK: ;
                        KEY_LEFT: begin
                            w_rd.en   = (r_left != '0);
                            w_rd.addr = ADDR_W'(r_left - CNT_W'(1));
                        end
                        KEY_RIGHT: begin
                            w_rd.en   = (r_right != '0);
                            w_rd.addr = w_base[ADDR_W-1:0];
                        end
                        default: begin
                            w_wr.en = !w_full;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                w_wr.en   = 1'b1;
                w_wr.data = w_rd_data;
                w_wr.addr = r_move_left ? ADDR_W'(w_base - CNT_W'(1))
                                        : r_left[ADDR_W-1:0];
            end
            S_FLUSH: begin
                w_rd.en = w_issue;
            end
            default: ;
        endcase
    end

    kle_gap_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_right     <= '0;
            r_ovf       <= 1'b0;
            r_move_left <= 1'b0;
            r_pos       <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_line.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_key_acc) begin
                        if (i_key.end_of_line) begin
                            r_pos     <= '0;
                            r_rd_pend <= 1'b0;
                            r_state   <= (w_total == '0) ? S_EMPTY : S_FLUSH;
                        end else begin
                            case (i_key.key)
                                KEY_BACK: begin
                                    if (r_left != '0) begin
                                        r_left <= r_left - CNT_W'(1);
                                    end
                                end
                                KEY_LEFT: begin
                                    if (r_left != '0) begin
                                        r_move_left <= 1'b1;
                                        r_state     <= S_MOVE;
                                    end
                                end
                                KEY_RIGHT: begin
                                    if (r_right != '0) begin
                                        r_move_left <= 1'b0;
                                        r_state     <= S_MOVE;
                                    end
                                end
                                default: begin
                                    if (w_full) begin
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_left <= r_left + CNT_W'(1);
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_MOVE: begin
                    if (r_move_left) begin
                        r_left  <= r_left - CNT_W'(1);
                        r_right <= r_right + CNT_W'(1);
                    end else begin
                        r_left  <= r_left + CNT_W'(1);
                        r_right <= r_right - CNT_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_FLUSH: begin
                    if (w_issue) begin
                        r_pos     <= r_pos + CNT_W'(1);
                        r_rd_pend <= 1'b1;
                        r_rd_last <= (r_pos == w_total - CNT_W'(1));
                    end else if (w_load) begin
                        r_rd_pend <= 1'b0;
                    end
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= w_rd_data;
                        r_out_has   <= 1'b1;
                        r_out_last  <= r_rd_last;
                        r_out_ovf   <= r_ovf;
                        if (r_rd_last) begin
                            r_left  <= '0;
                            r_right <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMPTY: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= '0;
                        r_out_has   <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_out_ovf   <= r_ovf;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_key.ready       = (r_state == S_IDLE);
    assign o_line.valid      = r_out_valid;
    assign o_line.text_char  = r_out_char;
    assign o_line.has_char   = r_out_has;
    assign o_line.last       = r_out_last;
    assign o_line.overflowed = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left + r_right) <= CNT_W'(LINE_DEPTH))
        else $error("line counts exceed store depth");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_line.valid && !o_line.has_char |-> o_line.last)
        else $error("result without character is not last");

    a_eol_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_acc && i_key.end_of_line |=> r_state == S_FLUSH || r_state == S_EMPTY)
        else $error("end of line did not start a flush");

    a_pend_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> r_state == S_FLUSH)
        else $error("store read pending outside flush");

endmodule
